// ===== src/atp_pkg.sv =====
// ----------------------------------------------------------------------------
// ASCII scan telegram parser package
// Shared types, byte codes, token positions and small lookup functions.
// ----------------------------------------------------------------------------
package atp_pkg;

	// Default width of the declared sample count and the streamed sample counter.
	localparam int ATP_COUNT_BITS = 16;
	// Default depth of the result queue (power of two, at least four).
	localparam int ATP_FIFO_DEPTH = 8;

	localparam int TOKEN_BITS = 17;

	// Byte codes.
	localparam logic [7:0] BYTE_STX   = 8'h02;
	localparam logic [7:0] BYTE_ETX   = 8'h03;
	localparam logic [7:0] BYTE_SPACE = 8'h20;

	// Token positions of the captured fields.
	localparam logic [TOKEN_BITS-1:0] TOK_UNIT_ID         = 17'd3;
	localparam logic [TOKEN_BITS-1:0] TOK_DEVICE_TIME     = 17'd10;
	localparam logic [TOKEN_BITS-1:0] TOK_SCAN_RATE       = 17'd16;
	localparam logic [TOKEN_BITS-1:0] TOK_OUT_CHANNEL     = 17'd19;
	localparam logic [TOKEN_BITS-1:0] TOK_SCALE           = 17'd21;
	localparam logic [TOKEN_BITS-1:0] TOK_FIRST_ANGLE     = 17'd23;
	localparam logic [TOKEN_BITS-1:0] TOK_ANGLE_INCREMENT = 17'd24;
	localparam logic [TOKEN_BITS-1:0] TOK_SAMPLE_COUNT    = 17'd25;
	localparam logic [TOKEN_BITS-1:0] TOK_FIRST_SAMPLE    = 17'd26;
	localparam logic [TOKEN_BITS-1:0] TOK_MIN_HEADER      = 17'd2;

	// Expected lengths of the command and subcommand tokens.
	localparam logic [3:0] LEN_CMD = 4'd3;
	localparam logic [3:0] LEN_SUB = 4'd11;

	typedef enum logic [1:0] {
		KIND_SAMPLE     = 2'd0,
		KIND_OK         = 2'd1,
		KIND_BAD_HEADER = 2'd2,
		KIND_SHORT      = 2'd3
	} kind_t;

	typedef struct packed {
		logic [31:0] angle_increment;
		logic [31:0] first_angle;
		logic [31:0] scale;
		logic [31:0] out_channel;
		logic [31:0] scan_rate;
		logic [31:0] device_time;
		logic [31:0] unit_id;
	} header_t;

	// Packed so that the lowest bits hold sample_index, matching the stream data layout.
	typedef struct packed {
		logic [31:0] largest_sample;
		logic [15:0] samples_declared;
		header_t     header;
		logic [31:0] sample_value;
		logic [15:0] sample_index;
	} result_data_t;

	typedef struct packed {
		kind_t        kind;
		result_data_t data;
	} result_t;

	// Returns the hex value of a character in the low four bits; bit 4 is set for a hex digit.
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

	// Expected character at a position of the command token ("sRA") or subcommand
	// token ("LMDscandata"); zero past the end of the text.
	function automatic logic [7:0] expected_char(input logic is_sub, input logic [3:0] pos);
		logic [7:0] r;
		r = 8'h00;
		if (!is_sub) begin
			case (pos)
				4'd0:    r = "s";
				4'd1:    r = "R";
				4'd2:    r = "A";
				default: r = 8'h00;
			endcase
		end else begin
			case (pos)
				4'd0:    r = "L";
				4'd1:    r = "M";
				4'd2:    r = "D";
				4'd3:    r = "s";
				4'd4:    r = "c";
				4'd5:    r = "a";
				4'd6:    r = "n";
				4'd7:    r = "d";
				4'd8:    r = "a";
				4'd9:    r = "t";
				4'd10:   r = "a";
				default: r = 8'h00;
			endcase
		end
		return r;
	endfunction

endpackage

// ===== src/atp_parser.sv =====
// ----------------------------------------------------------------------------
// Telegram parser stage
// Registers one byte, then updates the token and frame state and forms up to
// two results (a sample and a closing result) in the same cycle.
// ----------------------------------------------------------------------------
module atp_parser import atp_pkg::*; #(
	parameter int COUNT_BITS = ATP_COUNT_BITS
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    [7:0] in_byte,
	output logic    busy,
	output logic    res0_valid,
	output result_t res0,
	output logic    res1_valid,
	output result_t res1
);

	logic                  valid_s1;
	logic [7:0]            byte_s1;

	logic                  inside_q,  inside_n;
	logic [TOKEN_BITS-1:0] tok_q,     tok_n;
	logic [3:0]            cit_q,     cit_n;
	logic                  has_q,     has_n;
	logic                  hstop_q,   hstop_n;
	logic [31:0]           acc_q,     acc_n;
	logic                  tmatch_q,  tmatch_n;
	logic                  hgood_q,   hgood_n;
	header_t               hdr_q,     hdr_n;
	logic [COUNT_BITS-1:0] cnt_q,     cnt_n;
	logic [COUNT_BITS-1:0] done_q,    done_n;
	logic [31:0]           max_q,     max_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	assign busy = valid_s1;

	always_comb begin
		logic [4:0]  hex;
		logic [3:0]  exp_len;
		logic        is_sep;
		logic        emit;
		logic [31:0] done_ext;
		logic [31:0] cnt_ext;
		kind_t       close_kind;

		inside_n   = inside_q;
		tok_n      = tok_q;
		cit_n      = cit_q;
		has_n      = has_q;
		hstop_n    = hstop_q;
		acc_n      = acc_q;
		tmatch_n   = tmatch_q;
		hgood_n    = hgood_q;
		hdr_n      = hdr_q;
		cnt_n      = cnt_q;
		done_n     = done_q;
		max_n      = max_q;
		emit       = 1'b0;
		close_kind = KIND_OK;
		res1_valid = 1'b0;

		hex     = hex_decode(byte_s1);
		exp_len = (tok_q == '0) ? LEN_CMD : LEN_SUB;
		is_sep  = (byte_s1 == BYTE_SPACE) || (byte_s1 == BYTE_ETX);

		if (valid_s1) begin
			if (byte_s1 == BYTE_STX) begin
				inside_n = 1'b1;
				tok_n    = '0;
				hgood_n  = 1'b1;
				hdr_n    = '0;
				cnt_n    = '0;
				done_n   = '0;
				max_n    = '0;
				cit_n    = '0;
				has_n    = 1'b0;
				hstop_n  = 1'b0;
				acc_n    = '0;
				tmatch_n = 1'b1;
			end else if (inside_q && is_sep) begin
				if (has_q) begin
					if (tok_q <= TOKEN_BITS'(1) && (!tmatch_q || cit_q != exp_len)) begin
						hgood_n = 1'b0;
					end
					case (tok_q)
						TOK_UNIT_ID:         hdr_n.unit_id         = acc_q;
						TOK_DEVICE_TIME:     hdr_n.device_time     = acc_q;
						TOK_SCAN_RATE:       hdr_n.scan_rate       = acc_q;
						TOK_OUT_CHANNEL:     hdr_n.out_channel     = acc_q;
						TOK_SCALE:           hdr_n.scale           = acc_q;
						TOK_FIRST_ANGLE:     hdr_n.first_angle     = acc_q;
						TOK_ANGLE_INCREMENT: hdr_n.angle_increment = acc_q;
						TOK_SAMPLE_COUNT: begin
							if (|(acc_q >> COUNT_BITS)) begin
								cnt_n = '1;
							end else begin
								cnt_n = acc_q[COUNT_BITS-1:0];
							end
						end
						default: ;
					endcase
					if (tok_q >= TOK_FIRST_SAMPLE && hgood_n && done_q < cnt_q) begin
						emit = 1'b1;
						if (acc_q > max_q) begin
							max_n = acc_q;
						end
						done_n = done_q + 1'b1;
					end
					if (tok_q != '1) begin
						tok_n = tok_q + 1'b1;
					end
				end
				// A separator always leaves the token state as at the start of a token.
				cit_n    = '0;
				has_n    = 1'b0;
				hstop_n  = 1'b0;
				acc_n    = '0;
				tmatch_n = 1'b1;
				if (byte_s1 == BYTE_ETX) begin
					res1_valid = 1'b1;
					inside_n   = 1'b0;
					if (!hgood_n || tok_n < TOK_MIN_HEADER) begin
						close_kind = KIND_BAD_HEADER;
					end else if (tok_n < TOK_FIRST_SAMPLE || done_n < cnt_n) begin
						close_kind = KIND_SHORT;
					end else begin
						close_kind = KIND_OK;
					end
				end
			end else if (inside_q) begin
				if (tok_q <= TOKEN_BITS'(1)) begin
					if (cit_q >= exp_len
						|| expected_char(tok_q[0], cit_q) != byte_s1) begin
						tmatch_n = 1'b0;
					end
				end
				if (!hstop_q) begin
					if (!hex[4]) begin
						hstop_n = 1'b1;
					end else begin
						acc_n = {acc_q[27:0], hex[3:0]};
					end
				end
				if (cit_q != 4'hF) begin
					cit_n = cit_q + 1'b1;
				end
				has_n = 1'b1;
			end
		end

		cnt_ext  = 32'(cnt_n);
		done_ext = 32'(done_q);

		res0_valid                 = emit;
		res0.kind                  = KIND_SAMPLE;
		res0.data.largest_sample   = max_n;
		res0.data.samples_declared = cnt_ext[15:0];
		res0.data.header           = hdr_n;
		res0.data.sample_value     = acc_q;
		res0.data.sample_index     = done_ext[15:0];

		done_ext                   = 32'(done_n);
		res1.kind                  = close_kind;
		res1.data.largest_sample   = max_n;
		res1.data.samples_declared = cnt_ext[15:0];
		res1.data.header           = hdr_n;
		res1.data.sample_value     = '0;
		res1.data.sample_index     = done_ext[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			tok_q    <= '0;
			cit_q    <= '0;
			has_q    <= 1'b0;
			hstop_q  <= 1'b0;
			acc_q    <= '0;
			tmatch_q <= 1'b1;
			hgood_q  <= 1'b1;
			hdr_q    <= '0;
			cnt_q    <= '0;
			done_q   <= '0;
			max_q    <= '0;
		end else begin
			inside_q <= inside_n;
			tok_q    <= tok_n;
			cit_q    <= cit_n;
			has_q    <= has_n;
			hstop_q  <= hstop_n;
			acc_q    <= acc_n;
			tmatch_q <= tmatch_n;
			hgood_q  <= hgood_n;
			hdr_q    <= hdr_n;
			cnt_q    <= cnt_n;
			done_q   <= done_n;
			max_q    <= max_n;
		end
	end

endmodule

// ===== src/atp_out_fifo.sv =====
// ----------------------------------------------------------------------------
// Result queue
// Register-based queue that takes up to two results per cycle and hands one
// result per transfer to the output stream.
// ----------------------------------------------------------------------------
module atp_out_fifo import atp_pkg::*; #(
	parameter int DEPTH = ATP_FIFO_DEPTH
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr0_valid,
	input  result_t wr0_data,
	input  logic    wr1_valid,
	input  result_t wr1_data,
	input  logic    reserve,
	output logic    room,
	output logic    out_valid,
	output result_t out_data,
	input  logic    out_ready
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	result_t         mem [DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [CW-1:0]   count_q;
	logic            pop;
	logic [PW-1:0]   wr1_addr;
	logic [CW+1:0]   need;

	assign pop       = out_valid && out_ready;
	assign out_valid = (count_q != '0);
	assign out_data  = mem[rd_q];
	assign wr1_addr  = wr0_valid ? wr_q + 1'b1 : wr_q;

	// Space for two results from the byte now in the parser and two from the next one.
	assign need = (CW+2)'(count_q) + (reserve ? (CW+2)'(2) : (CW+2)'(0)) + (CW+2)'(2);
	assign room = (need <= (CW+2)'(DEPTH));

	always_ff @(posedge clk) begin
		if (wr0_valid) begin
			mem[wr_q] <= wr0_data;
		end
		if (wr1_valid) begin
			mem[wr1_addr] <= wr1_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + PW'(wr0_valid) + PW'(wr1_valid);
			rd_q    <= rd_q + PW'(pop);
			count_q <= count_q + CW'(wr0_valid) + CW'(wr1_valid) - CW'(pop);
		end
	end

endmodule

// ===== src/ascii_scan_telegram_parser.sv =====
// A byte that closes a token is registered in the parser, and its results are written into the result queue.
// Throughput: one byte per cycle while the output drains; a byte may yield two results.
// The rate is set by the parser stage and by the result queue's free space.
// Reset: arst_n clears all frame, token and queue state; the block waits for a start byte.
// ----------------------------------------------------------------------------
// ASCII scan telegram parser
// Parses scan-reply telegrams byte by byte and streams samples and a summary.
// ----------------------------------------------------------------------------
module ascii_scan_telegram_parser import atp_pkg::*; #(
	parameter int COUNT_BITS = ATP_COUNT_BITS,
	parameter int FIFO_DEPTH = ATP_FIFO_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] rx_byte
	output logic         m_tvalid,
	input  logic         m_tready,
	// [15:0] sample_index, [47:16] sample_value, [79:48] unit_id,
	// [111:80] device_time, [143:112] scan_rate, [175:144] out_channel,
	// [207:176] scale, [239:208] first_angle, [271:240] angle_increment,
	// [287:272] samples_declared, [319:288] largest_sample
	output logic [319:0] m_tdata,
	output logic [1:0]   m_tuser    // [1:0] kind
);

	// The input transfer loads the parser's byte register. In the next cycle the
	// parser updates its frame and token state and forms at most two results:
	// a sample, when a sample token closes, and a closing result at the end byte.
	// Both results go into the queue at the same clock edge, sample first.

	logic    parser_busy;
	logic    res0_valid;
	logic    res1_valid;
	result_t res0;
	result_t res1;
	result_t head;
	logic    room;

	// The block takes a byte only while the queue can absorb the results of the
	// byte in the parser and of the incoming byte, so no result is ever dropped.
	assign s_tready = room;

	atp_parser #(
		.COUNT_BITS (COUNT_BITS)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid && s_tready),
		.in_byte    (s_tdata),
		.busy       (parser_busy),
		.res0_valid (res0_valid),
		.res0       (res0),
		.res1_valid (res1_valid),
		.res1       (res1)
	);

	atp_out_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr0_valid (res0_valid),
		.wr0_data  (res0),
		.wr1_valid (res1_valid),
		.wr1_data  (res1),
		.reserve   (parser_busy),
		.room      (room),
		.out_valid (m_tvalid),
		.out_data  (head),
		.out_ready (m_tready)
	);

	// The result's data fields are packed lowest first, exactly as the struct lays them out.
	assign m_tdata = head.data;
	assign m_tuser = head.kind;

endmodule

// ===== tb/telegram_checker.sv =====
// ----------------------------------------------------------------------------
// Telegram result checker
// Follows every byte that the parser accepts, works out the results that the
// byte must produce, and compares each output transfer with the oldest one.
// ----------------------------------------------------------------------------
module telegram_checker import atp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [7:0]   s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [319:0] m_tdata,
	input  logic [1:0]   m_tuser,
	output int           mismatch_count,
	output int           results_pending
);

	localparam logic [23:0] CMD_TEXT   = "sRA";
	localparam logic [87:0] SUB_TEXT   = "LMDscandata";
	localparam logic [16:0] TOKEN_LAST = 17'h1FFFF;
	localparam logic [3:0]  POS_LAST   = 4'hF;

	logic        in_frame;
	logic [16:0] token_idx;
	logic [3:0]  char_pos;
	logic        token_open;
	logic        digits_done;
	logic [31:0] hex_acc;
	logic        text_ok;
	logic        header_ok;
	header_t     fields;
	logic [15:0] declared;
	logic [15:0] streamed;
	logic [31:0] peak;
	result_t     predicted_q[$];
	int          fail_cnt = 0;
	int          seen_cnt = 0;

	// Character that the command (sub = 0) or subcommand (sub = 1) text holds at pos.
	function automatic logic [7:0] header_char(input logic sub, input logic [3:0] pos);
		if (sub)
			return SUB_TEXT[8 * (10 - int'(pos)) +: 8];
		return CMD_TEXT[8 * (2 - int'(pos)) +: 8];
	endfunction

	// Value of a hex digit, or -1 for any other character.
	function automatic int digit_value(input logic [7:0] c);
		if (c >= "0" && c <= "9")
			return int'(c) - int'("0");
		if (c >= "a" && c <= "f")
			return int'(c) - int'("a") + 10;
		if (c >= "A" && c <= "F")
			return int'(c) - int'("A") + 10;
		return -1;
	endfunction

	task automatic clear_token();
		char_pos    = '0;
		token_open  = 1'b0;
		digits_done = 1'b0;
		hex_acc     = '0;
		text_ok     = 1'b1;
	endtask

	task automatic open_frame();
		in_frame  = 1'b1;
		token_idx = '0;
		header_ok = 1'b1;
		fields    = '0;
		declared  = '0;
		streamed  = '0;
		peak      = '0;
		clear_token();
	endtask

	task automatic push_prediction(input kind_t k, input logic [15:0] idx,
			input logic [31:0] value);
		result_t r;
		r.kind                  = k;
		r.data.sample_index     = idx;
		r.data.sample_value     = value;
		r.data.header           = fields;
		r.data.samples_declared = declared;
		r.data.largest_sample   = peak;
		predicted_q.push_back(r);
	endtask

	// A separator or the end byte closes the token; empty tokens are not counted.
	task automatic close_token();
		logic [3:0] want_len;
		if (token_open) begin
			if (token_idx <= 17'd1) begin
				want_len = (token_idx == 17'd0) ? LEN_CMD : LEN_SUB;
				if (!text_ok || char_pos != want_len)
					header_ok = 1'b0;
			end
			case (token_idx)
				TOK_UNIT_ID:         fields.unit_id         = hex_acc;
				TOK_DEVICE_TIME:     fields.device_time     = hex_acc;
				TOK_SCAN_RATE:       fields.scan_rate       = hex_acc;
				TOK_OUT_CHANNEL:     fields.out_channel     = hex_acc;
				TOK_SCALE:           fields.scale           = hex_acc;
				TOK_FIRST_ANGLE:     fields.first_angle     = hex_acc;
				TOK_ANGLE_INCREMENT: fields.angle_increment = hex_acc;
				TOK_SAMPLE_COUNT:    declared = (hex_acc > 32'hFFFF) ? 16'hFFFF : hex_acc[15:0];
				default: ;
			endcase
			if (token_idx >= TOK_FIRST_SAMPLE && header_ok && streamed < declared) begin
				if (hex_acc > peak)
					peak = hex_acc;
				push_prediction(KIND_SAMPLE, streamed, hex_acc);
				streamed++;
			end
			if (token_idx != TOKEN_LAST)
				token_idx++;
			clear_token();
		end
	endtask

	task automatic take_byte(input logic [7:0] c);
		logic [3:0] want_len;
		kind_t      k;
		int         d;
		if (c == BYTE_STX) begin
			open_frame();
		end else if (in_frame) begin
			if (c == BYTE_SPACE) begin
				close_token();
			end else if (c == BYTE_ETX) begin
				close_token();
				if (!header_ok || token_idx < TOK_MIN_HEADER)
					k = KIND_BAD_HEADER;
				else if (token_idx < TOK_FIRST_SAMPLE || streamed < declared)
					k = KIND_SHORT;
				else
					k = KIND_OK;
				push_prediction(k, streamed, 32'd0);
				in_frame = 1'b0;
			end else begin
				if (token_idx <= 17'd1) begin
					want_len = (token_idx == 17'd0) ? LEN_CMD : LEN_SUB;
					if (char_pos >= want_len || c != header_char(token_idx[0], char_pos))
						text_ok = 1'b0;
				end
				if (!digits_done) begin
					d = digit_value(c);
					if (d < 0)
						digits_done = 1'b1;
					else
						hex_acc = {hex_acc[27:0], d[3:0]};
				end
				if (char_pos != POS_LAST)
					char_pos++;
				token_open = 1'b1;
			end
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: result %0d field %s expected %h, got %h",
				$time, seen_cnt, name, want, got);
			fail_cnt++;
		end
	endtask

	task automatic check_transfer();
		result_t      want;
		result_data_t got;
		got = m_tdata;
		seen_cnt++;
		if (predicted_q.size() == 0) begin
			$display("%0t: result %0d expected none, got kind %0d index %0d value %h",
				$time, seen_cnt, m_tuser, got.sample_index, got.sample_value);
			fail_cnt++;
		end else begin
			want = predicted_q.pop_front();
			check_field("kind", 32'(want.kind), 32'(m_tuser));
			check_field("sample_index", 32'(want.data.sample_index), 32'(got.sample_index));
			check_field("sample_value", want.data.sample_value, got.sample_value);
			check_field("unit_id", want.data.header.unit_id, got.header.unit_id);
			check_field("device_time", want.data.header.device_time, got.header.device_time);
			check_field("scan_rate", want.data.header.scan_rate, got.header.scan_rate);
			check_field("out_channel", want.data.header.out_channel, got.header.out_channel);
			check_field("scale", want.data.header.scale, got.header.scale);
			check_field("first_angle", want.data.header.first_angle, got.header.first_angle);
			check_field("angle_increment", want.data.header.angle_increment,
				got.header.angle_increment);
			check_field("samples_declared", 32'(want.data.samples_declared),
				32'(got.samples_declared));
			check_field("largest_sample", want.data.largest_sample, got.largest_sample);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_frame();
			in_frame = 1'b0;
			predicted_q.delete();
		end else begin
			if (s_tvalid && s_tready)
				take_byte(s_tdata);
			if (m_tvalid && m_tready)
				check_transfer();
		end
		mismatch_count  <= fail_cnt;
		results_pending <= predicted_q.size();
	end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Scan telegram parser testbench
// Feeds directed and random scan-reply telegrams into the parser under four
// flow-control mixes and lets the checker compare every streamed result.
// ----------------------------------------------------------------------------
module testbench;
	import atp_pkg::*;

	// Even with two results per byte under the heaviest stalls a correct run ends
	// well within this limit, which leaves a wide margin.
	localparam int CYCLE_LIMIT = 200_000;
	// Least number of random bytes sent in each flow-control phase.
	localparam int PHASE_BYTES = 230;

	logic         clk      = 1'b0;
	logic         arst_n   = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata  = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [319:0] m_tdata;
	logic [1:0]   m_tuser;

	int src_idle_pct   = 0;
	int sink_stall_pct = 0;
	int bytes_sent     = 0;
	int cycle_count    = 0;
	int mismatch_total;
	int results_open;

	// The bytes of the telegrams to send, built completely before they are sent.
	logic [7:0] frame_q[$];

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	ascii_scan_telegram_parser DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	telegram_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.mismatch_count  (mismatch_total),
		.results_pending (results_open)
	);

	// The receiver drops tready at random, at the rate of the current phase.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Offers one byte, after a random number of idle cycles, and returns at the
	// edge where the transfer takes place.
	task automatic push_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_frame();
		foreach (frame_q[i])
			push_byte(frame_q[i]);
		frame_q.delete();
	endtask

	// Holds the input idle until every predicted result has been checked. The
	// first edge lets the checker account for the byte just transferred.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (results_open != 0)
			@(posedge clk);
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			frame_q.push_back(s[i]);
	endtask

	// Mostly a single space; now and then a run of spaces, which makes empty tokens.
	task automatic add_sep();
		int n;
		n = ($urandom_range(0, 7) == 0) ? int'($urandom_range(2, 3)) : 1;
		repeat (n) frame_q.push_back(BYTE_SPACE);
	endtask

	task automatic add_tokens(input int n, input string s);
		repeat (n) begin
			add_text(s);
			frame_q.push_back(BYTE_SPACE);
		end
	endtask

	function automatic logic [7:0] hex_char(input int d, input bit upper);
		if (d < 10)
			return 8'(int'("0") + d);
		return 8'((upper ? int'("A") : int'("a")) + d - 10);
	endfunction

	// Any byte that does not end a token.
	function automatic logic [7:0] token_byte();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (c == BYTE_STX || c == BYTE_ETX || c == BYTE_SPACE);
		return c;
	endfunction

	task automatic add_hex(input int n);
		repeat (n)
			frame_q.push_back(hex_char(int'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
	endtask

	task automatic add_junk(input int n);
		repeat (n) frame_q.push_back(token_byte());
	endtask

	// Hex text of v without leading zeros.
	task automatic add_number(input logic [31:0] v);
		int top;
		top = 0;
		for (int i = 0; i < 8; i++)
			if (v[4*i +: 4] != 4'd0)
				top = i;
		for (int i = top; i >= 0; i--)
			frame_q.push_back(hex_char(int'(v[4*i +: 4]), 1'($urandom_range(0, 1))));
	endtask

	// A numeric token as a device might send it, with the odd sign, prefix,
	// stray character, all-ones value or overlong digit string mixed in.
	task automatic add_value_token();
		int r;
		r = $urandom_range(0, 15);
		if (r == 0)
			frame_q.push_back(($urandom_range(0, 1) != 0) ? "-" : "+");
		else if (r == 1)
			add_text("0x");
		r = $urandom_range(0, 9);
		if (r < 2) begin
			repeat (8) frame_q.push_back(hex_char(15, 1'($urandom_range(0, 1))));
		end else if (r < 4) begin
			add_hex($urandom_range(9, 20));
		end else begin
			add_hex($urandom_range(1, 8));
		end
		if ($urandom_range(0, 7) == 0) begin
			frame_q.push_back(token_byte());
			add_hex($urandom_range(1, 3));
		end
	endtask

	// Command or subcommand text, either exact or damaged in one of several ways.
	task automatic add_name(input string s, input bit damaged);
		int p;
		if (!damaged) begin
			add_text(s);
		end else begin
			case ($urandom_range(0, 3))
				0: begin
					p = $urandom_range(0, s.len() - 1);
					for (int i = 0; i < s.len(); i++)
						frame_q.push_back((i == p) ? token_byte() : s[i]);
				end
				1: begin
					add_text(s);
					frame_q.push_back(token_byte());
				end
				2: begin
					for (int i = 0; i < s.len() - 1; i++)
						frame_q.push_back(s[i]);
				end
				default: begin
					add_text(s);
					add_junk($urandom_range(3, 8));
				end
			endcase
		end
		add_sep();
	endtask

	// One random telegram. Most are well formed with random content, so that
	// samples and summaries are reached; the rest carry a damaged header, end
	// early, lose their end byte, or are plain line noise.
	task automatic add_random_telegram();
		int style;
		int stop_tok;
		int n_samples;
		int r;
		logic [31:0] count;
		style = $urandom_range(0, 99);
		frame_q.push_back(BYTE_STX);
		if (style < 8) begin
			repeat ($urandom_range(1, 24)) frame_q.push_back(8'($urandom_range(0, 255)));
		end else begin
			add_name("sRA", style < 14);
			add_name("LMDscandata", style >= 14 && style < 20);
			stop_tok = (style >= 20 && style < 26) ? int'($urandom_range(2, 25)) : 26;
			for (int t = 2; t < 25 && t < stop_tok; t++) begin
				if (t == 3 || t == 10 || t == 16 || t == 19 || t == 21 || t == 23 || t == 24)
					add_value_token();
				else if ($urandom_range(0, 3) == 0)
					add_junk($urandom_range(1, 5));
				else
					add_hex($urandom_range(1, 3));
				add_sep();
			end
			if (stop_tok == 26) begin
				r = $urandom_range(0, 15);
				if (r < 2) begin
					// A wide count, which normally saturates and leaves the scan short.
					add_hex(8);
					n_samples = $urandom_range(0, 4);
				end else begin
					count = $urandom_range(0, 6);
					add_number(count);
					n_samples = (r < 5) ? int'($urandom_range(0, count))
						: int'(count) + int'($urandom_range(0, 2));
				end
				add_sep();
				repeat (n_samples) begin
					add_value_token();
					add_sep();
				end
			end
		end
		if ($urandom_range(0, 24) != 0)
			frame_q.push_back(BYTE_ETX);
		// Line noise between telegrams, which the parser must ignore.
		if ($urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 4)) frame_q.push_back(token_byte());
	endtask

	task automatic run_directed();
		// Bytes outside a telegram, the extremes among them, are dropped.
		frame_q.push_back(8'h00);
		frame_q.push_back(8'hFF);
		frame_q.push_back(BYTE_ETX);
		frame_q.push_back(BYTE_SPACE);
		frame_q.push_back("A");
		// A complete scan: a signed and a prefixed field that read as zero, an
		// overlong field that keeps its low 32 bits, an all-ones sample, an empty
		// token, and a sample beyond the declared count that is ignored.
		frame_q.push_back(BYTE_STX);
		add_text("sRA LMDscandata 1 -5 0 0 0 0 0 0 0x1F 0 0 0 0 0 123456789AB 0 0 ");
		add_text("ffffffff 0 Ab9 0 FFF80000 1388 3 FFFFFFFF  0 12345678 99");
		frame_q.push_back(BYTE_ETX);
		// A start byte inside a telegram throws the partial one away; then a
		// scan that declares no samples at all.
		frame_q.push_back(BYTE_STX);
		add_text("sRA LMD");
		frame_q.push_back(BYTE_STX);
		add_text("sRA LMDscandata ");
		add_tokens(23, "7");
		add_text("0");
		frame_q.push_back(BYTE_ETX);
		// Wrong command, a lone token, an empty telegram and an overlong
		// subcommand all report a header mismatch.
		frame_q.push_back(BYTE_STX);
		add_text("sRB LMDscandata 1 2");
		frame_q.push_back(BYTE_ETX);
		frame_q.push_back(BYTE_STX);
		add_text("sRA");
		frame_q.push_back(BYTE_ETX);
		frame_q.push_back(BYTE_STX);
		frame_q.push_back(BYTE_ETX);
		frame_q.push_back(BYTE_STX);
		add_text("sRA LMDscandataXXXXXXX 1");
		frame_q.push_back(BYTE_ETX);
		// A good header that stops before the sample count is short.
		frame_q.push_back(BYTE_STX);
		add_text("sRA LMDscandata 5 6 7");
		frame_q.push_back(BYTE_ETX);
		// A count beyond 16 bits saturates, so two samples leave the scan short.
		frame_q.push_back(BYTE_STX);
		add_text("sRA LMDscandata ");
		add_tokens(23, "1");
		add_text("FFFFF 1 2");
		frame_q.push_back(BYTE_ETX);
		// The largest sample must hold over a smaller one and a repeat of itself.
		frame_q.push_back(BYTE_STX);
		add_text("sRA LMDscandata ");
		add_tokens(23, "2");
		add_text("4 5 9 3 9");
		frame_q.push_back(BYTE_ETX);
		send_frame();
	endtask

	initial begin
		int phase_start;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		// Let the directed results drain completely before the random part.
		drain();

		// Flow-control phases: free running, idle sender, stalling receiver, both.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					src_idle_pct   = 0;
					sink_stall_pct <= 0;
				end
				1: begin
					src_idle_pct   = 79;
					sink_stall_pct <= 0;
				end
				2: begin
					src_idle_pct   = 0;
					sink_stall_pct <= 79;
				end
				default: begin
					src_idle_pct   = 10;
					sink_stall_pct <= 10;
				end
			endcase
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < PHASE_BYTES) begin
				add_random_telegram();
				send_frame();
			end
			drain();
		end

		// A few more cycles catch any result that the parser should not send.
		repeat (20) @(posedge clk);
		if (mismatch_total == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
